>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_SPACE     = 8'd32;

    // a space closer than this to the right edge breaks the line
    localparam int EDGE_GAP = 6;

    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [0:0] REG_MAX_COLUMNS = 1'b0;
    localparam logic [0:0] REG_MAX_ROWS    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_LOOK,
        S_BS_LAST,
        S_BS_MARK,
        S_PUT,
        S_DRAW,
        S_BACK,
        S_BACK_LAST
    } state_t;

endpackage

`default_nettype wire

>>> rtl/text_console_cursor_engine.sv
// Channel  Dir  Beat fields (low bit up)                          Handshake
// s_*      in   tdata: char_code[7:0]; tuser: erasable[0]        s_tvalid/s_tready
// m_*      out  tdata: glyph[7:0] col[15:8] row[22:16] pad[23];  m_tvalid/m_tready
//               tuser: kind[0]; tlast: final beat of the item
// cfg_*    in   cfg_index: register, cfg_data: value             cfg_valid/cfg_ready
//
// Ordinary character: accept, put and draw steps before the next accept; a line
// break skips the draw step. Backspace: its steps follow the chain of dependent,
// registered reads of the row length memory and the erasable mark memory. A clear
// beat keeps the sequencer in the draw step for its draw beat; output stalls hold
// the sequencer in the draw step. After reset all (MAX_ROWS+1)*MAX_COLS entries of
// the mark memory (33024 at the defaults) are swept to zero; s_tready stays low until then, config is taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_engine #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code[7:0]
    input  logic [0:0]  s_tuser,    // erasable[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // glyph_code[7:0], cell_column[15:8], cell_row[22:16]
    output logic [0:0]  m_tuser,    // kind[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    import tcce_pkg::*;

    localparam int CW         = $clog2(MAX_COLS + 1);
    localparam int LW         = $clog2(MAX_COLS);
    localparam int RW         = $clog2(MAX_ROWS + 1);
    localparam int LD         = MAX_ROWS + 1;
    localparam int MARK_DEPTH = (MAX_ROWS + 1) * MAX_COLS;
    localparam int MW         = $clog2(MARK_DEPTH);
    localparam int CXW        = (CW > 9) ? CW : 9;
    localparam int RXW        = (RW > 8) ? RW : 8;
    localparam int COLS_RST   = (213 > MAX_COLS) ? MAX_COLS : 213;
    localparam int ROWS_RST   = (67 > MAX_ROWS) ? MAX_ROWS : 67;

    function automatic logic [CW-1:0] clamp_cols(input logic [8:0] v);
        logic [CW-1:0] r;
        if (v == 9'd0)
            r = CW'(1);
        else if (CXW'(v) > CXW'(MAX_COLS))
            r = CW'(MAX_COLS);
        else
            r = CW'(v);
        return r;
    endfunction

    function automatic logic [RW-1:0] clamp_rows(input logic [7:0] v);
        logic [RW-1:0] r;
        if (v == 8'd0)
            r = RW'(1);
        else if (RXW'(v) > RXW'(MAX_ROWS))
            r = RW'(MAX_ROWS);
        else
            r = RW'(v);
        return r;
    endfunction

    function automatic logic [MW-1:0] mark_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return MW'(r) * MW'(MAX_COLS) + MW'(c);
    endfunction

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   cols_reg;
    logic [RW-1:0]   rows_reg;
    logic            out_valid_reg;
    logic            clr_busy_reg;
    logic [MW-1:0]   clr_addr_reg;
    logic [LD-1:0]   last_vld_reg;

    // item payload
    logic [7:0]      code_reg, code_next;
    logic            eras_reg, eras_next;
    logic            bs_reg, bs_next;
    logic [LW-1:0]   tmp_reg, tmp_next;
    logic            out_kind_reg;
    logic [7:0]      out_glyph_reg;
    logic [7:0]      out_col_reg;
    logic [6:0]      out_row_reg;

    // memories
    logic [LW-1:0]   last_mem [LD];
    logic            mark_mem [MARK_DEPTH];
    logic [LW-1:0]   last_rd_reg;
    logic            last_vld_rd_reg;
    logic            mark_rd_reg;

    // memory controls
    logic            mark_we;
    logic [MW-1:0]   mark_waddr;
    logic            mark_wdata;
    logic [MW-1:0]   mark_raddr;
    logic            last_we;
    logic [RW-1:0]   last_waddr;
    logic [LW-1:0]   last_wdata;
    logic [RW-1:0]   last_raddr;
    logic            last_clear;

    // emitted beat
    logic            emit;
    logic            emit_kind;
    logic [7:0]      emit_glyph;
    logic [CW+7:0]   emit_col_ext;
    logic [RW+6:0]   emit_row_ext;

    // decoded conditions
    logic            in_acc;
    logic            slot_free;
    logic            col_nz;
    logic            row_nz;
    logic            line_brk;
    logic            wrap;
    logic            row_full;
    logic [CW-1:0]   col_dec;
    logic [RW-1:0]   row_dec;
    logic [RW-1:0]   row_inc;
    logic [LW-1:0]   last_val;

    assign in_acc    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign col_nz    = col_reg != '0;
    assign row_nz    = row_reg != '0;
    assign col_dec   = col_reg - CW'(1);
    assign row_dec   = row_reg - RW'(1);
    assign row_inc   = (row_reg < RW'(MAX_ROWS)) ? row_reg + RW'(1) : RW'(MAX_ROWS);
    assign wrap      = col_reg >= cols_reg;
    assign row_full  = row_reg >= rows_reg;
    assign last_val  = last_vld_rd_reg ? last_rd_reg : '0;
    assign line_brk  = (code_reg == CODE_NEWLINE) ||
                       ((code_reg == CODE_SPACE) &&
                        ((CW+1)'(col_reg) + (CW+1)'(EDGE_GAP) > (CW+1)'(cols_reg)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = (s_tdata == CODE_BACKSPACE) ? S_BS_LOOK : S_PUT;
            end
            S_BS_LOOK:
            begin
                if (col_nz)
                    state_next = S_BS_MARK;
                else if (row_nz)
                    state_next = S_BS_LAST;
                else
                    state_next = S_IDLE;
            end
            S_BS_LAST:
                state_next = S_BS_MARK;
            S_BS_MARK:
                state_next = mark_rd_reg ? S_PUT : S_IDLE;
            S_PUT:
            begin
                if (!line_brk)
                    state_next = S_DRAW;
                else
                    state_next = bs_reg ? S_BACK : S_IDLE;
            end
            S_DRAW:
            begin
                if (!row_full && slot_free)
                    state_next = bs_reg ? S_BACK : S_IDLE;
            end
            S_BACK:
                state_next = (!col_nz && row_nz) ? S_BACK_LAST : S_IDLE;
            S_BACK_LAST:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_tready     = (state_reg == S_IDLE) && !clr_busy_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        code_next    = code_reg;
        eras_next    = eras_reg;
        bs_next      = bs_reg;
        tmp_next     = tmp_reg;
        mark_we      = 1'b0;
        mark_waddr   = mark_addr(row_reg, col_reg);
        mark_wdata   = 1'b0;
        mark_raddr   = '0;
        last_we      = 1'b0;
        last_waddr   = row_reg;
        last_wdata   = '0;
        last_raddr   = '0;
        last_clear   = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_DRAW;
        emit_glyph   = code_reg;
        emit_col_ext = (CW+8)'(col_reg);
        emit_row_ext = (RW+7)'(row_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    code_next = s_tdata;
                    eras_next = s_tuser[0];
                    bs_next   = s_tdata == CODE_BACKSPACE;
                end
            end
            S_BS_LOOK:
            begin
                if (col_nz)
                    mark_raddr = mark_addr(row_reg, col_dec);
                else
                    last_raddr = row_dec;
            end
            S_BS_LAST:
            begin
                // previous cell is the last-index cell of the row above
                tmp_next   = last_val;
                mark_raddr = mark_addr(row_dec, CW'(last_val));
            end
            S_BS_MARK:
            begin
                if (mark_rd_reg)
                begin
                    code_next = CODE_SPACE;
                    if (col_nz)
                    begin
                        col_next   = col_dec;
                        last_we    = 1'b1;
                        last_waddr = row_reg;
                        last_wdata = col_dec[LW-1:0];
                    end
                    else
                    begin
                        row_next = row_dec;
                        col_next = CW'(tmp_reg);
                    end
                end
            end
            S_PUT:
            begin
                if (line_brk || wrap)
                begin
                    col_next   = '0;
                    row_next   = row_inc;
                    mark_we    = 1'b1;
                    mark_waddr = mark_addr(row_inc, '0);
                    mark_wdata = 1'b1;
                    last_we    = 1'b1;
                    last_waddr = row_inc;
                    last_wdata = '0;
                end
            end
            S_DRAW:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (row_full)
                    begin
                        // off the bottom: clear beat first, draw follows at the origin
                        emit_kind    = KIND_CLEAR;
                        emit_glyph   = '0;
                        emit_col_ext = '0;
                        emit_row_ext = '0;
                        last_clear   = 1'b1;
                        col_next     = '0;
                        row_next     = '0;
                    end
                    else
                    begin
                        mark_we    = 1'b1;
                        mark_waddr = mark_addr(row_reg, col_reg);
                        mark_wdata = eras_reg;
                        last_we    = 1'b1;
                        last_waddr = row_reg;
                        last_wdata = col_reg[LW-1:0];
                        col_next   = col_reg + CW'(1);
                    end
                end
            end
            S_BACK:
            begin
                if (col_nz)
                begin
                    col_next   = col_dec;
                    last_we    = 1'b1;
                    last_waddr = row_reg;
                    last_wdata = col_dec[LW-1:0];
                end
                else if (row_nz)
                begin
                    last_raddr = row_dec;
                end
            end
            S_BACK_LAST:
            begin
                row_next = row_dec;
                col_next = CW'(last_val);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cols_reg      <= CW'(COLS_RST);
            rows_reg      <= RW'(ROWS_RST);
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            last_vld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_COLUMNS: cols_reg <= clamp_cols(cfg_data);
                    REG_MAX_ROWS:    rows_reg <= clamp_rows(cfg_data[7:0]);
                endcase
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + MW'(1);
                if (clr_addr_reg == MW'(MARK_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (last_clear)
                last_vld_reg <= '0;
            else if (last_we)
                last_vld_reg[last_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        eras_reg <= eras_next;
        bs_reg   <= bs_next;
        tmp_reg  <= tmp_next;
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_glyph_reg <= emit_glyph;
            out_col_reg   <= emit_col_ext[7:0];
            out_row_reg   <= emit_row_ext[6:0];
        end
    end

    // row length memory, valid bits give the zero reset and the screen clear
    always_ff @(posedge clk)
    begin
        if (last_we)
            last_mem[last_waddr] <= last_wdata;
        last_rd_reg     <= last_mem[last_raddr];
        last_vld_rd_reg <= last_vld_reg[last_raddr];
    end

    // erasable marks, swept to zero after reset
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mark_mem[clr_addr_reg] <= 1'b0;
        else if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        mark_rd_reg <= mark_mem[mark_raddr];
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_row_reg, out_col_reg, out_glyph_reg};
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_kind_reg == KIND_DRAW;

    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, s_tvalid && s_tready, state_reg != S_IDLE, "accepted beat did not start the sequencer")
    `ASSERT_NEXT(a_clear_then_draw, clk, rst_n, m_tvalid && m_tready && (out_kind_reg == KIND_CLEAR), m_tvalid && (out_kind_reg == KIND_DRAW), "clear beat not followed by its draw beat")
    `ASSERT_HOLDS(a_draw_on_screen, clk, rst_n, emit && (emit_kind == KIND_DRAW), row_reg < rows_reg, "draw beat issued below the last row")
    `ASSERT_HOLDS(a_cursor_bounds, clk, rst_n, 1'b1, (col_reg <= CW'(MAX_COLS)) && (row_reg <= RW'(MAX_ROWS)), "cursor outside the stored area")

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import tcce_pkg::*;

    localparam int COLS_LIMIT    = 256;
    localparam int ROWS_LIMIT    = 128;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [7:0] code;
        logic       erasable;
    } char_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] glyph;
        logic [7:0] col;
        logic [6:0] row;
        logic       last;
    } cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_MAX_COLUMNS;
    logic [8:0]  cfg_data = '0;

    text_console_cursor_engine #(
        .MAX_COLS (COLS_LIMIT),
        .MAX_ROWS (ROWS_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // console model: registers, cursor, row lengths and erasable marks
    int       width_reg = 213;
    int       height_reg = 67;
    int       cur_col = 0;
    int       cur_row = 0;
    bit [7:0] row_end [0:ROWS_LIMIT];
    bit       cell_mark [0:ROWS_LIMIT][0:COLS_LIMIT-1];
    cmd_t     item_cmds [2];
    int       n_item_cmds;

    char_t pending_chars [$];
    cmd_t  expected_cmds [$];
    char_t next_char;
    cmd_t  got;
    cmd_t  want;

    int chars_queued = 0;
    int chars_sent = 0;
    int cmds_checked = 0;
    int clears_seen = 0;
    int reg_writes = 0;
    int errors = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int stall_reqs = 0;
    int stall_served = 0;
    int stall_left = 0;

    function automatic int cols_in_use();
        if (width_reg == 0)
            return 1;
        if (width_reg > COLS_LIMIT)
            return COLS_LIMIT;
        return width_reg;
    endfunction

    function automatic int rows_in_use();
        if (height_reg == 0)
            return 1;
        if (height_reg > ROWS_LIMIT)
            return ROWS_LIMIT;
        return height_reg;
    endfunction

    function automatic void line_break();
        cur_col = 0;
        if (cur_row < ROWS_LIMIT)
            cur_row++;
        cell_mark[cur_row][0] = 1'b1;
        row_end[cur_row] = '0;
    endfunction

    function automatic void step_left();
        if (cur_col > 0)
        begin
            cur_col--;
            row_end[cur_row] = cur_col[7:0];
        end
        else if (cur_row > 0)
        begin
            cur_row--;
            cur_col = int'(row_end[cur_row]);
        end
    endfunction

    function automatic bit left_erasable();
        if (cur_col > 0)
            return cell_mark[cur_row][cur_col-1];
        if (cur_row > 0)
            return cell_mark[cur_row-1][row_end[cur_row-1]];
        return 1'b0;
    endfunction

    function automatic void add_cmd(logic kind, logic [7:0] glyph, int col, int row);
        cmd_t c;
        if (n_item_cmds >= 2)
            return;
        c.kind = kind;
        c.glyph = glyph;
        c.col = col[7:0];
        c.row = row[6:0];
        c.last = 1'b0;
        item_cmds[n_item_cmds] = c;
        n_item_cmds++;
    endfunction

    function automatic void place_char(logic [7:0] code, logic mark);
        if ((code == CODE_SPACE && cur_col + EDGE_GAP > cols_in_use()) || code == CODE_NEWLINE)
        begin
            line_break();
            return;
        end
        if (cur_col >= cols_in_use())
            line_break();
        if (cur_row >= rows_in_use())
        begin
            // screen full: clear, forget row lengths, keep the marks
            add_cmd(KIND_CLEAR, 8'h00, 0, 0);
            foreach (row_end[r])
                row_end[r] = '0;
            cur_col = 0;
            cur_row = 0;
        end
        add_cmd(KIND_DRAW, code, cur_col, cur_row);
        cell_mark[cur_row][cur_col] = mark;
        row_end[cur_row] = cur_col[7:0];
        cur_col++;
    endfunction

    function automatic void predict_char(logic [7:0] code, logic mark);
        n_item_cmds = 0;
        if (code == CODE_BACKSPACE)
        begin
            if (left_erasable())
            begin
                step_left();
                place_char(CODE_SPACE, mark);
                step_left();
            end
        end
        else
            place_char(code, mark);
        if (n_item_cmds > 0)
            item_cmds[n_item_cmds-1].last = 1'b1;
        for (int i = 0; i < n_item_cmds; i++)
            expected_cmds.push_back(item_cmds[i]);
    endfunction

    // character driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_char(s_tdata, s_tuser[0]);
                chars_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_char = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_char.code;
                    s_tuser <= next_char.erasable;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_served != stall_reqs)
        begin
            stall_served <= stall_served + 1;
            stall_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // command monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser[0];
            got.glyph = m_tdata[7:0];
            got.col = m_tdata[15:8];
            got.row = m_tdata[22:16];
            got.last = m_tlast;
            if (got.kind == KIND_CLEAR)
                clears_seen++;
            if (expected_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: expected none, got kind %0d glyph %02h col %0d row %0d last %0d",
                         $time, got.kind, got.glyph, got.col, got.row, got.last);
            end
            else
            begin
                want = expected_cmds.pop_front();
                cmds_checked++;
                if (got.kind !== want.kind || got.glyph !== want.glyph || got.col !== want.col
                    || got.row !== want.row || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch: expected kind %0d glyph %02h col %0d row %0d last %0d",
                             $time, want.kind, want.glyph, want.col, want.row, want.last);
                    $display("%0t:           got kind %0d glyph %02h col %0d row %0d last %0d",
                             $time, got.kind, got.glyph, got.col, got.row, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out, %0d characters sent, %0d commands outstanding",
                     $time, chars_sent, expected_cmds.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_char(logic [7:0] code, logic mark);
        pending_chars.push_back('{code: code, erasable: mark});
        chars_queued++;
    endtask

    // call at a rising edge with the engine idle
    task automatic write_reg(logic [0:0] idx, logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_MAX_COLUMNS)
            width_reg = int'(value);
        else
            height_reg = int'(value[7:0]);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // newlines give no beat, so allow the sequencer to finish after the last one
    task automatic wait_idle();
        do
            @(posedge clk);
        while (chars_sent != chars_queued || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int cols, int rows, int count, int nl_pct, int bs_pct,
                             int sp_pct, int src_idle, int sink_idle, bit hold);
        int  typed;
        int  pick;
        bit  mark;
        src_idle_pct = src_idle;
        sink_idle_pct = sink_idle;
        write_reg(REG_MAX_COLUMNS, cols[8:0]);
        write_reg(REG_MAX_ROWS, rows[8:0]);
        typed = 0;
        while (typed < count)
        begin
            pick = $urandom_range(99);
            mark = ($urandom_range(9) != 0);
            if (pick < nl_pct)
                queue_char(CODE_NEWLINE, mark);
            else if (pick < nl_pct + bs_pct)
                repeat ($urandom_range(4, 1)) queue_char(CODE_BACKSPACE, 1'($urandom_range(1)));
            else if (pick < nl_pct + bs_pct + sp_pct)
                queue_char(CODE_SPACE, mark);
            else
                queue_char(8'($urandom_range(255)), mark);
            if (pick < nl_pct || pick >= nl_pct + bs_pct)
                typed++;
        end
        if (hold)
            stall_reqs++;
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 8 columns, 2 rows
        src_idle_pct = 19;
        sink_idle_pct = 88;
        write_reg(REG_MAX_COLUMNS, 9'd8);
        write_reg(REG_MAX_ROWS, 9'd2);
        queue_char("A", 1'b1);
        queue_char(CODE_BACKSPACE, 1'b1);   // erases the A
        queue_char(CODE_BACKSPACE, 1'b1);   // at home: nothing to erase
        queue_char(8'hFF, 1'b0);
        queue_char(8'h00, 1'b1);
        queue_char(CODE_BACKSPACE, 1'b0);   // erases the 00
        queue_char(CODE_BACKSPACE, 1'b1);   // FF is protected
        queue_char(CODE_SPACE, 1'b1);       // far from the edge: drawn
        queue_char(CODE_NEWLINE, 1'b0);
        queue_char(CODE_BACKSPACE, 1'b1);   // erase back across the row boundary
        queue_char(CODE_NEWLINE, 1'b1);
        for (int k = 0; k < 8; k++)
            queue_char(8'(8'h61 + k), 1'b1);
        queue_char("i", 1'b0);              // right margin wrap, then clear past last row
        queue_char(CODE_BACKSPACE, 1'b1);
        queue_char(CODE_SPACE, 1'b1);
        queue_char(CODE_SPACE, 1'b1);
        queue_char(CODE_SPACE, 1'b1);       // near the edge: line break
        queue_char(8'h0D, 1'b1);            // control code is just a glyph
        wait_idle();

        run_phase(0, 0, 40, 10, 15, 15, 19, 88, 1'b0);
        run_phase(40, 6, 60, 8, 15, 15, 19, 88, 1'b0);
        run_phase(256, 2, 320, 0, 3, 2, 88, 19, 1'b0);
        run_phase(511, 255, 220, 60, 10, 5, 88, 19, 1'b0);
        run_phase(30, 5, 60, 8, 15, 12, 0, 0, 1'b1);
        run_phase(1, 1, 40, 10, 20, 20, 0, 0, 1'b0);
        run_phase(213, 128, 40, 5, 15, 15, 0, 0, 1'b0);

        if (expected_cmds.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected commands never arrived", $time, expected_cmds.size());
        end
        $display("summary: %0d chars, %0d register writes, widths 1-256, heights 1-128",
                 chars_sent, reg_writes);
        $display("summary: %0d commands checked, %0d screen clears, %0d mismatches",
                 cmds_checked, clears_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> text_console_cursor_engine.f
+incdir+rtl
rtl/tcce_pkg.sv
rtl/text_console_cursor_engine.sv
verif/tb.sv
